/* rtl/particle_power_attractor_macros.svh */
// Assertion macros shared by the attractor RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef PARTICLE_POWER_ATTRACTOR_MACROS_SVH
`define PARTICLE_POWER_ATTRACTOR_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define PPA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never hold outside reset.
`define PPA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/ppa_pkg.sv */
// Shared types, constants and elaboration-time functions of the attractor.
// No dependencies; every RTL module imports this package.
package ppa_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int LOG_FRAC      = 16;
	localparam int MANT_BITS     = 30;
	localparam int LG_W          = 24;
	localparam int STRENGTH_RST  = 2560;

	localparam logic [2:0] REG_TARGET_X     = 3'd0;
	localparam logic [2:0] REG_TARGET_Y     = 3'd1;
	localparam logic [2:0] REG_TARGET_Z     = 3'd2;
	localparam logic [2:0] REG_STRENGTH     = 3'd3;
	localparam logic [2:0] REG_CONVERGE_INV = 3'd4;

	typedef struct packed {
		logic [31:0]        lifetime;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
	} out_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pos_t;

	typedef struct packed {
		logic vld;
		logic zero;
	} ctl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		rem = v;
		for (int j = 0; j < 32; j++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-k) in Q2.30, each entry the floor square root of the one before.
	function automatic logic [31:0] root_const(input int k);
		logic [63:0] r;
		r = 64'd2 << MANT_BITS;
		for (int j = 1; j <= k; j++)
			r = isqrt64(r << MANT_BITS);
		return r[31:0];
	endfunction

endpackage

/* rtl/ppa_log.sv */
// Normalised age and its base-two logarithm by repeated squaring.
// Depends on ppa_pkg; eighteen register stages.
module ppa_log #(
	parameter int FRAC_BITS = ppa_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppa_pkg::ctl_t                 ctl_i,
	input  logic [63:0]                   prod,
	input  ppa_pkg::pos_t                 pos_i,
	output ppa_pkg::ctl_t                 ctl_o,
	output logic signed [ppa_pkg::LG_W-1:0] lg_o,
	output ppa_pkg::pos_t                 pos_o
);
	import ppa_pkg::*;

	logic [63:0] x_w;
	logic [5:0]  p_w;
	logic [63:0] x_s1;
	logic [5:0]  p_s1;
	ctl_t        ctl_s1;
	pos_t        pos_s1;

	logic [63:0]       sh_w;
	logic signed [7:0] e_w;

	logic [31:0]            m_s   [LOG_FRAC+1];
	logic signed [LG_W-1:0] lg_s  [LOG_FRAC+1];
	ctl_t                   ctl_s [LOG_FRAC+1];
	pos_t                   pos_s [LOG_FRAC+1];

	assign x_w = prod >> FRAC_BITS;

	always_comb begin
		p_w = '0;
		for (int i = 0; i < 64; i++)
			if (x_w[i]) p_w = 6'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld  <= ctl_i.vld;
			ctl_s1.zero <= (x_w == '0);
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= x_w;
		p_s1   <= p_w;
		pos_s1 <= pos_i;
	end

	// The leading one goes to bit 63, so the top word is the Q1.31 mantissa.
	assign sh_w = x_s1 << (6'd63 - p_s1);
	assign e_w  = $signed({2'b00, p_s1}) - 8'(FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[0] <= '0;
		else ctl_s[0] <= ctl_s1;
	end

	always_ff @(posedge clk) begin
		m_s[0]   <= sh_w[63:32];
		lg_s[0]  <= {e_w, 16'b0};
		pos_s[0] <= pos_s1;
	end

	for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
		logic [63:0] sq_w;
		logic [32:0] m2_w;

		assign sq_w = 64'(m_s[k]) * 64'(m_s[k]);
		assign m2_w = sq_w[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[k+1] <= '0;
			else ctl_s[k+1] <= ctl_s[k];
		end

		always_ff @(posedge clk) begin
			pos_s[k+1] <= pos_s[k];
			if (m2_w[32]) begin
				m_s[k+1]  <= m2_w[32:1];
				lg_s[k+1] <= lg_s[k] | (LG_W'(1) << (LOG_FRAC - 1 - k));
			end else begin
				m_s[k+1]  <= m2_w[31:0];
				lg_s[k+1] <= lg_s[k];
			end
		end
	end

	assign ctl_o = ctl_s[LOG_FRAC];
	assign lg_o  = lg_s[LOG_FRAC];
	assign pos_o = pos_s[LOG_FRAC];

endmodule

/* rtl/ppa_exp.sv */
// Scales the logarithm by strength and raises two to it, giving t.
// Depends on ppa_pkg; eighteen register stages.
module ppa_exp #(
	parameter int FRAC_BITS = ppa_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [15:0]                     strength,
	input  ppa_pkg::ctl_t                   ctl_i,
	input  logic signed [ppa_pkg::LG_W-1:0] lg_i,
	input  ppa_pkg::pos_t                   pos_i,
	output ppa_pkg::ctl_t                   ctl_o,
	output logic [32+FRAC_BITS:0]           t_o,
	output ppa_pkg::pos_t                   pos_o
);
	import ppa_pkg::*;

	localparam int TW = 33 + FRAC_BITS;
	localparam logic [TW-1:0] TCAP = TW'(1) << (32 + FRAC_BITS);
	localparam logic [TW-1:0] ONE  = TW'(1) << FRAC_BITS;

	logic signed [40:0] yp_w;

	logic [31:0]        mant_s [LOG_FRAC+1];
	logic signed [16:0] n_s    [LOG_FRAC+1];
	logic [15:0]        f_s    [LOG_FRAC+1];
	ctl_t               ctl_s  [LOG_FRAC+1];
	pos_t               pos_s  [LOG_FRAC+1];

	logic signed [17:0] s_w;
	logic [17:0]        ns_w;
	logic [62:0]        wide_w;
	logic [TW-1:0]      t_w;
	logic [TW-1:0]      t_q;
	ctl_t               ctl_q;
	pos_t               pos_q;

	// Floor division by 256 is the arithmetic shift taken as a bit select.
	assign yp_w = $signed({1'b0, strength}) * lg_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[0] <= '0;
		else ctl_s[0] <= ctl_i;
	end

	always_ff @(posedge clk) begin
		n_s[0]    <= yp_w[40:24];
		f_s[0]    <= yp_w[23:8];
		mant_s[0] <= 32'd1 << MANT_BITS;
		pos_s[0]  <= pos_i;
	end

	for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_root
		localparam logic [31:0] ROOT = root_const(k);
		logic [63:0] mp_w;

		assign mp_w = 64'(mant_s[k-1]) * 64'(ROOT);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[k] <= '0;
			else ctl_s[k] <= ctl_s[k-1];
		end

		always_ff @(posedge clk) begin
			n_s[k]   <= n_s[k-1];
			f_s[k]   <= f_s[k-1];
			pos_s[k] <= pos_s[k-1];
			if (f_s[k-1][LOG_FRAC-k]) mant_s[k] <= mp_w[61:30];
			else mant_s[k] <= mant_s[k-1];
		end
	end

	assign s_w    = $signed({n_s[LOG_FRAC][16], n_s[LOG_FRAC]}) + 18'(FRAC_BITS)
		- 18'(MANT_BITS);
	assign ns_w   = 18'(-s_w);
	assign wide_w = 63'(mant_s[LOG_FRAC]) << s_w[4:0];

	always_comb begin
		if (strength == '0) begin
			t_w = ONE;
		end else if (ctl_s[LOG_FRAC].zero) begin
			t_w = '0;
		end else if (!s_w[17]) begin
			if (s_w > 18'sd31) t_w = TCAP;
			else if (wide_w > 63'(TCAP)) t_w = TCAP;
			else t_w = wide_w[TW-1:0];
		end else if (ns_w >= 18'd32) begin
			t_w = '0;
		end else begin
			t_w = TW'(mant_s[LOG_FRAC] >> ns_w[4:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= '0;
		else ctl_q <= ctl_s[LOG_FRAC];
	end

	always_ff @(posedge clk) begin
		t_q   <= t_w;
		pos_q <= pos_s[LOG_FRAC];
	end

	assign ctl_o = ctl_q;
	assign t_o   = t_q;
	assign pos_o = pos_q;

endmodule

/* rtl/ppa_blend.sv */
// One coordinate lane: pos + sign(d)*floor(|d|*t) with saturation.
// Depends on ppa_pkg; three register stages, payload only.
module ppa_blend #(
	parameter int FRAC_BITS = ppa_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic signed [31:0]     pos,
	input  logic signed [31:0]     tgt,
	input  logic [32+FRAC_BITS:0]  t,
	output logic signed [31:0]     res
);
	import ppa_pkg::*;

	localparam int LW = 33 + FRAC_BITS;

	logic signed [32:0] d_w;
	logic               dz_s1, neg_s1, thbig_s1;
	logic [32:0]        mag_s1;
	logic [31:0]        th_s1;
	logic [FRAC_BITS-1:0] tl_s1;
	logic signed [31:0] pos_s1;

	logic [64:0]        hi_w;
	logic [LW-1:0]      lo_w;
	logic               dz_s2, neg_s2, big_s2;
	logic [33:0]        hi_s2;
	logic [32:0]        lo_s2;
	logic signed [31:0] pos_s2;

	logic [34:0]        sum_w;
	logic signed [35:0] r_w;
	logic signed [31:0] res_w;
	logic signed [31:0] res_s3;

	assign d_w = $signed({tgt[31], tgt}) - $signed({pos[31], pos});

	always_ff @(posedge clk) begin
		dz_s1    <= (d_w == '0);
		neg_s1   <= d_w[32];
		mag_s1   <= d_w[32] ? 33'(-d_w) : 33'(d_w);
		thbig_s1 <= t[32+FRAC_BITS];
		th_s1    <= t[31+FRAC_BITS:FRAC_BITS];
		tl_s1    <= t[FRAC_BITS-1:0];
		pos_s1   <= pos;
	end

	assign hi_w = 65'(mag_s1) * 65'(th_s1);
	assign lo_w = LW'(mag_s1) * LW'(tl_s1);

	always_ff @(posedge clk) begin
		dz_s2  <= dz_s1;
		neg_s2 <= neg_s1;
		big_s2 <= thbig_s1 || (hi_w[64:34] != '0);
		hi_s2  <= hi_w[33:0];
		lo_s2  <= lo_w[LW-1:FRAC_BITS];
		pos_s2 <= pos_s1;
	end

	assign sum_w = 35'(hi_s2) + 35'(lo_s2);
	assign r_w   = neg_s2 ? ({{4{pos_s2[31]}}, pos_s2} - $signed({1'b0, sum_w}))
		: ({{4{pos_s2[31]}}, pos_s2} + $signed({1'b0, sum_w}));

	always_comb begin
		if (dz_s2) res_w = pos_s2;
		else if (big_s2) res_w = neg_s2 ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else if (r_w > 36'sh0_7fff_ffff) res_w = 32'sh7fff_ffff;
		else if (r_w < -36'sh0_8000_0000) res_w = 32'sh8000_0000;
		else res_w = r_w[31:0];
	end

	always_ff @(posedge clk) begin
		res_s3 <= res_w;
	end

	assign res = res_s3;

endmodule

/* rtl/particle_power_attractor.sv */
// Particle attractor top level: register file, age multiplier and the three stages.
// Depends on ppa_pkg, ppa_log, ppa_exp, ppa_blend and the assertion macros.
// One request is taken every cycle, as the 18-stage log and 18-stage exp pipelines
// give each squaring or root step its own multiplier. busy stays low and results
// cannot be held off. Reset clears the valid bits and loads the register defaults;
// no clearing pass is needed.
`include "particle_power_attractor_macros.svh"

module particle_power_attractor #(
	parameter int FRAC_BITS = ppa_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ppa_pkg::in_t  request,
	output logic          done,
	output ppa_pkg::out_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import ppa_pkg::*;

	localparam int TW  = 33 + FRAC_BITS;
	localparam int LAT = 40;

	logic signed [31:0] target_x_q, target_y_q, target_z_q;
	logic [15:0]        strength_q;
	logic [31:0]        converge_inv_q;
	logic [2:0]         idx_w;
	logic               wr_w;

	logic [63:0] prod_s1;
	pos_t        pos_s1;
	ctl_t        ctl_s1;

	ctl_t                   ctl_l;
	logic signed [LG_W-1:0] lg_l;
	pos_t                   pos_l;
	ctl_t                   ctl_x;
	logic [TW-1:0]          t_x;
	pos_t                   pos_x;

	logic vld_b_s1, vld_b_s2, vld_b_s3;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign idx_w  = paddr[4:2];
	assign wr_w   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q     <= '0;
			target_y_q     <= '0;
			target_z_q     <= '0;
			strength_q     <= 16'(STRENGTH_RST);
			converge_inv_q <= 32'd1 << FRAC_BITS;
		end else if (wr_w) begin
			unique case (idx_w)
				REG_TARGET_X:     target_x_q     <= pwdata;
				REG_TARGET_Y:     target_y_q     <= pwdata;
				REG_TARGET_Z:     target_z_q     <= pwdata;
				REG_STRENGTH:     strength_q     <= pwdata[15:0];
				REG_CONVERGE_INV: converge_inv_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx_w)
			REG_TARGET_X:     prdata = target_x_q;
			REG_TARGET_Y:     prdata = target_y_q;
			REG_TARGET_Z:     prdata = target_z_q;
			REG_STRENGTH:     prdata = {16'b0, strength_q};
			REG_CONVERGE_INV: prdata = converge_inv_q;
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s1 <= '0;
		else ctl_s1 <= '{vld: start && !busy, zero: 1'b0};
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(request.lifetime) * 64'(converge_inv_q);
		pos_s1  <= '{x: request.pos_x, y: request.pos_y, z: request.pos_z};
	end

	ppa_log #(.FRAC_BITS(FRAC_BITS)) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_s1),
		.prod   (prod_s1),
		.pos_i  (pos_s1),
		.ctl_o  (ctl_l),
		.lg_o   (lg_l),
		.pos_o  (pos_l)
	);

	ppa_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.strength (strength_q),
		.ctl_i    (ctl_l),
		.lg_i     (lg_l),
		.pos_i    (pos_l),
		.ctl_o    (ctl_x),
		.t_o      (t_x),
		.pos_o    (pos_x)
	);

	ppa_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_x (
		.clk (clk),
		.pos (pos_x.x),
		.tgt (target_x_q),
		.t   (t_x),
		.res (result.new_x)
	);

	ppa_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_y (
		.clk (clk),
		.pos (pos_x.y),
		.tgt (target_y_q),
		.t   (t_x),
		.res (result.new_y)
	);

	ppa_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_z (
		.clk (clk),
		.pos (pos_x.z),
		.tgt (target_z_q),
		.t   (t_x),
		.res (result.new_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b_s1 <= 1'b0;
			vld_b_s2 <= 1'b0;
			vld_b_s3 <= 1'b0;
		end else begin
			vld_b_s1 <= ctl_x.vld;
			vld_b_s2 <= vld_b_s1;
			vld_b_s3 <= vld_b_s2;
		end
	end

	assign done = vld_b_s3;

	// A result only ever appears for a request that has passed through the whole pipeline.
	`PPA_ASSERT_IMPL(a_done_has_request, done, $past(start && !busy, LAT), "done without request")
	// With a zero age and a non-zero exponent the weight must be zero.
	`PPA_ASSERT_IMPL(a_zero_age_weight, ctl_x.vld && ctl_x.zero && strength_q != '0, t_x == '0, "zero age gave non-zero t")
	// The weight of a valid request never exceeds its ceiling.
	`PPA_ASSERT_IMPL(a_weight_cap, ctl_x.vld, t_x <= (TW'(1) << (32 + FRAC_BITS)), "t above its cap")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the particle attractor: drives particles and register
// writes, predicts each new position in fixed point and compares it with the result.
// Depends on ppa_pkg and the particle_power_attractor RTL.
module tb_top;
	import ppa_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         request;
	logic        done;
	out_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	particle_power_attractor dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor copy of the registers.
	longint      tgt_x, tgt_y, tgt_z;
	logic [15:0] cfg_strength;
	logic [31:0] cfg_conv;
	logic [63:0] roots [0:16];

	out_t        expected_pos [$];
	int          idle_pct;
	int          mismatches;
	int          checked;
	int          sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Normalised age raised to the strength, with 16 fraction bits, held at 2^48.
	function automatic logic [63:0] age_power(logic [31:0] life);
		logic [63:0] x;
		logic [63:0] m;
		logic [63:0] mant;
		logic [63:0] cap;
		longint      lg, y, n, f, s;
		int          p;
		cap = 64'd1 << 48;
		x = ({32'b0, life} * {32'b0, cfg_conv}) >> 16;
		if (cfg_strength == 0) return 64'd1 << 16;
		if (x == 0) return 64'd0;
		p = 63;
		while (!x[p]) p--;
		m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
		lg = longint'(p - 16) * 65536;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				lg += longint'(1) << i;
				m = m >> 1;
			end
		end
		y = (longint'(cfg_strength) * lg) >>> 8;
		n = y >>> 16;
		f = y & 65535;
		mant = 64'd1 << 30;
		for (int i = 1; i <= 16; i++)
			if (f[16 - i]) mant = (mant * roots[i]) >> 30;
		s = n - 14;
		if (s >= 0) begin
			if (s > 31) return cap;
			mant = mant << s;
			return (mant > cap) ? cap : mant;
		end
		if (-s >= 63) return 64'd0;
		return mant >> (-s);
	endfunction

	function automatic logic [31:0] pull_coord(logic signed [31:0] pos, longint tgt,
			logic [63:0] t);
		longint      d, res, p;
		logic [63:0] mag, th, tl, hi;
		p = pos;
		d = tgt - p;
		if (d == 0) return pos;
		mag = (d > 0) ? d : -d;
		th = t >> 16;
		tl = t & 64'hFFFF;
		if (th >= 64'h1_0000_0000) return (d > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
		hi = mag * th;
		if (hi >= (64'd1 << 34)) return (d > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
		hi += (mag * tl) >> 16;
		res = (d > 0) ? p + longint'(hi) : p - longint'(hi);
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		return res[31:0];
	endfunction

	// Record the expected position of every request taken by the block.
	always @(posedge clk) begin
		logic [63:0] t;
		out_t        e;
		if (arst_n && start && !busy) begin
			t = age_power(request.lifetime);
			e.new_x = pull_coord(request.pos_x, tgt_x, t);
			e.new_y = pull_coord(request.pos_y, tgt_y, t);
			e.new_z = pull_coord(request.pos_z, tgt_z, t);
			expected_pos.push_back(e);
		end
	end

	always @(posedge clk) begin
		out_t e;
		if (arst_n && done) begin
			if (expected_pos.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				e = expected_pos.pop_front();
				checked++;
				if (result.new_x !== e.new_x || result.new_y !== e.new_y ||
						result.new_z !== e.new_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %h, got %h %h %h",
							e.new_x, e.new_y, e.new_z,
							result.new_x, result.new_y, result.new_z);
				end
			end
		end
	end

	task automatic send_particle(logic [31:0] life, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= '{lifetime: life, pos_x: px, pos_y: py, pos_z: pz};
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (expected_pos.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_TARGET_X:     tgt_x = longint'(signed'(val));
			REG_TARGET_Y:     tgt_y = longint'(signed'(val));
			REG_TARGET_Z:     tgt_z = longint'(signed'(val));
			REG_STRENGTH:     cfg_strength = val[15:0];
			REG_CONVERGE_INV: cfg_conv = val;
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_attractor(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
			logic [15:0] str, logic [31:0] conv);
		drain();
		reg_write(REG_TARGET_X, tx);
		reg_write(REG_TARGET_Y, ty);
		reg_write(REG_TARGET_Z, tz);
		reg_write(REG_STRENGTH, {16'b0, str});
		reg_write(REG_CONVERGE_INV, conv);
	endtask

	function automatic logic [31:0] pick_age();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h18000, 32'h8000);
			2: return $urandom_range(32'h40000);
			default: return ($urandom_range(5) == 0) ? 32'd0 : $urandom_range(32'hFF);
		endcase
	endfunction

	function automatic logic [31:0] pick_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
		endcase
	endfunction

	task automatic test_directed;
		// Defaults first: zero age keeps the position, large ages overshoot.
		send_particle(32'd0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
		send_particle(32'h0001_0000, 32'h0010_0000, 32'hFFF0_0000, 32'd0);
		send_particle(32'h0000_8000, 32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_particle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		send_particle(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000);
		send_particle(32'd1, 32'h4000_0000, 32'hC000_0000, 32'h0000_FFFF);
		// Zero strength: every particle lands on the target, zero age too.
		set_attractor(32'h0005_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 16'd0, 32'h0001_0000);
		send_particle(32'd0, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
		send_particle(32'hFFFF_FFFF, 32'h1111_1111, 32'hFFFB_0000, 32'h7FFF_FFFF);
		// Maximum strength and converge factor, then a zero converge factor.
		set_attractor(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF);
		send_particle(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_particle(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000);
		send_particle(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_0000);
		send_particle(32'h0000_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
		set_attractor(32'h0003_0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0100, 32'd0);
		send_particle(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
		// Linear strength, a write to an unused index which must change nothing.
		set_attractor(32'h0010_0000, 32'hFFF0_0000, 32'h0000_0000, 16'h0100, 32'h0001_0000);
		reg_write(3'd5, 32'hFFFF_FFFF);
		send_particle(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_particle(32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_particle(32'h0001_8000, 32'hFFF0_0000, 32'h0010_0000, 32'h1234_0000);
	endtask

	task automatic test_settings_sweep;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_attractor(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd2560,
					32'h0001_0000);
				1: set_attractor(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'hFFFF,
					32'hFFFF_FFFF);
				2: set_attractor(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd0,
					32'd0);
				default: set_attractor($urandom, $urandom, pick_pos(),
					16'($urandom_range(16'h0800)), $urandom_range(32'h40000));
			endcase
			idle_pct = (ph == 3) ? 0 : 14;
			for (int i = 0; i < 100; i++)
				send_particle(pick_age(), pick_pos(), pick_pos(), pick_pos());
		end
		idle_pct = 14;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tgt_x = 0;
		tgt_y = 0;
		tgt_z = 0;
		cfg_strength = 16'(STRENGTH_RST);
		cfg_conv = 32'h0001_0000;
		idle_pct = 14;
		mismatches = 0;
		checked = 0;
		sent = 0;
		roots[0] = 64'd2 << 30;
		for (int k = 1; k <= 16; k++) roots[k] = floor_sqrt(roots[k - 1] << 30);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings_sweep();
		drain();
		repeat (60) @(posedge clk);
		if (expected_pos.size() != 0) mismatches++;
		$display("Sent %0d particles over extreme and random attractor settings,", sent);
		$display("%0d positions checked, %0d mismatches.", checked, mismatches);
		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
